[rtl/core/masked_pixel_bin_average_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the masked pixel bin average block
// Shared overlapping-implication and next-cycle property forms. Each macro
// expects clk and rst_n to be visible in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MASKED_PIXEL_BIN_AVERAGE_TOP_DEFINES_SVH
`define MASKED_PIXEL_BIN_AVERAGE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mpba_pkg.sv]
// ----------------------------------------------------------------------------
// mpba_pkg
// Shared widths, register indexes, reset values and the queue item flags
// of the masked pixel bin average block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpba_pkg;

    // Register and port field widths.
    localparam int BW_W       = 7;
    localparam int SW_W       = 13;
    localparam int OW_W       = 11;
    localparam int OH_W       = 13;
    localparam int COL_W      = 12;
    localparam int OROW_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PORT_PIX_W = 16;
    localparam int OUT_VAL_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT   = 3'd4;

    // Upper limits of the source width and output height registers.
    localparam logic [SW_W-1:0] SRC_WIDTH_MAX  = 13'd4096;
    localparam logic [OH_W-1:0] OUT_HEIGHT_MAX = 13'd4096;

    // Register values after reset.
    localparam logic [BW_W-1:0] BIN_WIDTH_RST    = 7'd2;
    localparam logic [BW_W-1:0] BIN_HEIGHT_RST   = 7'd2;
    localparam logic [SW_W-1:0] SOURCE_WIDTH_RST = 13'd1024;
    localparam logic [OW_W-1:0] OUT_WIDTH_RST    = 11'd512;
    localparam logic [OH_W-1:0] OUT_HEIGHT_RST   = 13'd512;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Classification of one pixel, decided by the front.
    typedef struct packed {
        logic pix_valid;
        logic first;
        logic last;
        logic row_end;
        logic frame_end;
    } item_flags_t;

endpackage

`default_nettype wire

[rtl/core/masked_pixel_bin_average_top.sv]
// ----------------------------------------------------------------------------
// masked_pixel_bin_average_top
// Masked 2-D pixel binning with a truncated mean per block.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per pixel, each with its mask bit;
// every bin_width by bin_height block gives one result beat with its mean,
// has_data, row_end and frame_end. The front takes one pixel beat per cycle
// into a four-entry queue while it has room; pixels outside the binned area
// and after the frame's last output row are dropped there at once. The back
// does a read-modify-write of the column accumulator memory for each binned
// pixel, a read state and then a write state; the pixel that completes a
// block adds the mean division, one quotient bit per cycle, skipped if it had
// no valid pixel. A result waits in the output register while the back goes
// on with later pixels; the next completed block holds the back until that
// result has been taken. Any write to a listed register restarts the frame
// and must be issued only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_pixel_bin_average_top #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int PIXEL_BITS    = 16,
    parameter int MAX_BIN       = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [mpba_pkg::PORT_PIX_W-1:0]  pixel,
    input  wire                              valid_req,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [mpba_pkg::OUT_VAL_W-1:0]   binned_value,
    output logic                             has_data,
    output logic                             row_end,
    output logic                             frame_end,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [mpba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [mpba_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mpba_pkg::*;

    localparam int ADDR_W  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int CNT_W   = $clog2(MAX_BIN * MAX_BIN + 1);
    localparam int SUM_W   = PIXEL_BITS + $clog2(MAX_BIN * MAX_BIN);
    localparam int FLAGS_W = $bits(item_flags_t);
    localparam int FIFO_W  = PIXEL_BITS + ADDR_W + FLAGS_W;

    logic                  push_valid;
    logic                  push_ready;
    logic [PIXEL_BITS-1:0] push_pixel;
    logic [ADDR_W-1:0]     push_slot;
    item_flags_t           push_flags;
    logic [FIFO_W-1:0]     fifo_wdata;
    logic [FIFO_W-1:0]     fifo_rdata;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [PIXEL_BITS-1:0] pop_pixel;
    logic [ADDR_W-1:0]     pop_slot;
    item_flags_t           pop_flags;

    // Register writes are always taken at once.
    assign cfg_ready = 1'b1;

    mpba_front #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .PIXEL_BITS    (PIXEL_BITS),
        .MAX_BIN       (MAX_BIN),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .valid_req  (valid_req),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pixel (push_pixel),
        .push_slot  (push_slot),
        .push_flags (push_flags)
    );

    // Pack and unpack the queue items.
    assign fifo_wdata = {push_pixel, push_slot, push_flags};
    assign pop_pixel  = fifo_rdata[FIFO_W-1 -: PIXEL_BITS];
    assign pop_slot   = fifo_rdata[FLAGS_W +: ADDR_W];
    assign pop_flags  = item_flags_t'(fifo_rdata[FLAGS_W-1:0]);

    mpba_fifo #(
        .DATA_W (FIFO_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (fifo_wdata),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (fifo_rdata)
    );

    mpba_back #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .PIXEL_BITS    (PIXEL_BITS),
        .ADDR_W        (ADDR_W),
        .CNT_W         (CNT_W),
        .SUM_W         (SUM_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_pixel    (pop_pixel),
        .pop_slot     (pop_slot),
        .pop_flags    (pop_flags),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .binned_value (binned_value),
        .has_data     (has_data),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

endmodule

`default_nettype wire

[rtl/core/mpba_front.sv]
// ----------------------------------------------------------------------------
// mpba_front
// Holds the configuration registers and the raster position counters,
// takes one pixel beat per cycle while the queue has room and classifies it for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_pixel_bin_average_top_defines.svh"

module mpba_front #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int PIXEL_BITS    = 16,
    parameter int MAX_BIN       = 64,
    parameter int ADDR_W        = 10
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [mpba_pkg::PORT_PIX_W-1:0]   pixel,
    input  wire                               valid_req,
    input  wire                               cfg_valid,
    input  wire  [mpba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [mpba_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              push_valid,
    input  wire                               push_ready,
    output logic [PIXEL_BITS-1:0]             push_pixel,
    output logic [ADDR_W-1:0]                 push_slot,
    output mpba_pkg::item_flags_t             push_flags
);
    import mpba_pkg::*;

    // Configuration registers.
    logic [BW_W-1:0] bin_width_reg, bin_width_next;
    logic [BW_W-1:0] bin_height_reg, bin_height_next;
    logic [SW_W-1:0] src_width_reg, src_width_next;
    logic [OW_W-1:0] out_width_reg, out_width_next;
    logic [OH_W-1:0] out_height_reg, out_height_next;

    // Raster position.
    logic [COL_W-1:0]  col_reg, col_next;
    logic [BW_W-1:0]   sub_reg, sub_next;
    logic [OW_W-1:0]   bin_reg, bin_next;
    logic [BW_W-1:0]   row_reg, row_next;
    logic [OROW_W-1:0] orow_reg, orow_next;
    logic              frame_done_reg, frame_done_next;

    logic [BW_W-1:0] cfg_bw_val;
    logic [BW_W-1:0] cfg_bh_val;
    logic [SW_W-1:0] cfg_sw_val;
    logic [OW_W-1:0] cfg_ow_val;
    logic [OH_W-1:0] cfg_oh_val;
    logic            restart;

    logic [SW_W-1:0] col_inc;
    logic [BW_W-1:0] sub_inc;
    logic [BW_W-1:0] row_inc;
    logic            in_range;
    logic            last_col;
    logic            in_accept;

    // Clamp the written value: zero becomes one, too large becomes the maximum.
    assign cfg_bw_val = (cfg_data[BW_W-1:0] == '0) ? BW_W'(1) :
                        (32'(cfg_data[BW_W-1:0]) > MAX_BIN) ? BW_W'(MAX_BIN) :
                        cfg_data[BW_W-1:0];
    assign cfg_bh_val = (cfg_data[BW_W-1:0] == '0) ? BW_W'(1) :
                        (32'(cfg_data[BW_W-1:0]) > MAX_BIN) ? BW_W'(MAX_BIN) :
                        cfg_data[BW_W-1:0];
    assign cfg_sw_val = (cfg_data[SW_W-1:0] == '0) ? SW_W'(1) :
                        (cfg_data[SW_W-1:0] > SRC_WIDTH_MAX) ? SRC_WIDTH_MAX :
                        cfg_data[SW_W-1:0];
    assign cfg_ow_val = (cfg_data[OW_W-1:0] == '0) ? OW_W'(1) :
                        (32'(cfg_data[OW_W-1:0]) > MAX_OUT_WIDTH) ? OW_W'(MAX_OUT_WIDTH) :
                        cfg_data[OW_W-1:0];
    assign cfg_oh_val = (cfg_data[OH_W-1:0] == '0) ? OH_W'(1) :
                        (cfg_data[OH_W-1:0] > OUT_HEIGHT_MAX) ? OUT_HEIGHT_MAX :
                        cfg_data[OH_W-1:0];

    // Classify the pixel at the current raster position.
    assign in_range = bin_reg < out_width_reg;
    assign last_col = bin_reg == (out_width_reg - OW_W'(1));

    assign push_pixel           = pixel[PIXEL_BITS-1:0];
    assign push_slot            = ADDR_W'(bin_reg);
    assign push_flags.pix_valid = valid_req;
    assign push_flags.first     = (row_reg == '0) && (sub_reg == '0);
    assign push_flags.last      = (row_reg == (bin_height_reg - BW_W'(1))) &&
                                  (sub_reg == (bin_width_reg - BW_W'(1)));
    assign push_flags.row_end   = last_col;
    assign push_flags.frame_end = last_col &&
                                  (OH_W'(orow_reg) == (out_height_reg - OH_W'(1)));

    // Pixels outside the binned area and after the frame are dropped at once.
    assign push_valid = in_valid && !frame_done_reg && in_range;
    assign in_ready   = frame_done_reg || !in_range || push_ready;
    assign in_accept  = in_valid && in_ready;

    assign col_inc = SW_W'(col_reg) + SW_W'(1);
    assign sub_inc = sub_reg + BW_W'(1);
    assign row_inc = row_reg + BW_W'(1);

    // Next state of the registers and the raster counters.
    always_comb
    begin
        bin_width_next  = bin_width_reg;
        bin_height_next = bin_height_reg;
        src_width_next  = src_width_reg;
        out_width_next  = out_width_reg;
        out_height_next = out_height_reg;
        col_next        = col_reg;
        sub_next        = sub_reg;
        bin_next        = bin_reg;
        row_next        = row_reg;
        orow_next       = orow_reg;
        frame_done_next = frame_done_reg;
        restart         = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BIN_WIDTH:
                begin
                    bin_width_next = cfg_bw_val;
                    restart        = 1'b1;
                end
                REG_BIN_HEIGHT:
                begin
                    bin_height_next = cfg_bh_val;
                    restart         = 1'b1;
                end
                REG_SOURCE_WIDTH:
                begin
                    src_width_next = cfg_sw_val;
                    restart        = 1'b1;
                end
                REG_OUT_WIDTH:
                begin
                    out_width_next = cfg_ow_val;
                    restart        = 1'b1;
                end
                REG_OUT_HEIGHT:
                begin
                    out_height_next = cfg_oh_val;
                    restart         = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        if (restart)
        begin
            col_next        = '0;
            sub_next        = '0;
            bin_next        = '0;
            row_next        = '0;
            orow_next       = '0;
            frame_done_next = 1'b0;
        end
        else if (in_accept && !frame_done_reg)
        begin
            if (col_inc >= src_width_reg)
            begin
                // End of a source row.
                col_next = '0;
                sub_next = '0;
                bin_next = '0;
                if (row_inc >= bin_height_reg)
                begin
                    row_next = '0;
                    if (OH_W'(orow_reg) >= (out_height_reg - OH_W'(1)))
                    begin
                        frame_done_next = 1'b1;
                    end
                    else
                    begin
                        orow_next = orow_reg + OROW_W'(1);
                    end
                end
                else
                begin
                    row_next = row_inc;
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                if (sub_inc == bin_width_reg)
                begin
                    sub_next = '0;
                    if (bin_reg != out_width_reg)
                    begin
                        bin_next = bin_reg + OW_W'(1);
                    end
                end
                else
                begin
                    sub_next = sub_inc;
                end
            end
        end
    end

    // Register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg  <= BIN_WIDTH_RST;
            bin_height_reg <= BIN_HEIGHT_RST;
            src_width_reg  <= SOURCE_WIDTH_RST;
            out_width_reg  <= OUT_WIDTH_RST;
            out_height_reg <= OUT_HEIGHT_RST;
            col_reg        <= '0;
            sub_reg        <= '0;
            bin_reg        <= '0;
            row_reg        <= '0;
            orow_reg       <= '0;
            frame_done_reg <= 1'b0;
        end
        else
        begin
            bin_width_reg  <= bin_width_next;
            bin_height_reg <= bin_height_next;
            src_width_reg  <= src_width_next;
            out_width_reg  <= out_width_next;
            out_height_reg <= out_height_next;
            col_reg        <= col_next;
            sub_reg        <= sub_next;
            bin_reg        <= bin_next;
            row_reg        <= row_next;
            orow_reg       <= orow_next;
            frame_done_reg <= frame_done_next;
        end
    end

    // The bin index saturates at the output width and never passes it.
    `MPBA_ASSERT_IMPL(a_bin_in_bounds, 1'b1, bin_reg <= out_width_reg, "bin index past width")
    // The column within a bin stays below the bin width.
    `MPBA_ASSERT_IMPL(a_sub_in_bin, 1'b1, sub_reg < bin_width_reg, "sub-column out of bin")
    // The row within a bin stays below the bin height.
    `MPBA_ASSERT_IMPL(a_row_in_bin, 1'b1, row_reg < bin_height_reg, "row out of bin")

endmodule

`default_nettype wire

[rtl/core/mpba_fifo.sv]
// ----------------------------------------------------------------------------
// mpba_fifo
// Short register queue that decouples the classifying front from the
// accumulating back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_pixel_bin_average_top_defines.svh"

module mpba_fifo #(
    parameter int DATA_W = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  wire  [DATA_W-1:0]   push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output logic [DATA_W-1:0]   pop_data
);
    import mpba_pkg::*;

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic              push_en;
    logic              pop_en;

    assign push_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_en    = push_valid && push_ready;
    assign pop_en     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push_en && !pop_en)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (pop_en && !push_en)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill level follows every push and pop exactly.
    `MPBA_ASSERT_NEXT(a_count_tracks, 1'b1, count_reg == ($past(count_reg) + $past(push_en) - $past(pop_en)), "queue level mismatch")

endmodule

`default_nettype wire

[rtl/core/mpba_div.sv]
// ----------------------------------------------------------------------------
// mpba_div
// Restoring divider for the block mean, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpba_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 13
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire  [NUM_W-1:0]   num,
    input  wire  [DEN_W-1:0]   den,
    output logic               done,
    output logic [NUM_W-1:0]   quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_sh   = {rem_reg, quo_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
    assign quo_next = {quo_reg[NUM_W-2:0], ge};

    assign done = done_reg;
    assign quo  = quo_reg;

    // Step counter and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Working remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mpba_back.sv]
// ----------------------------------------------------------------------------
// mpba_back
// Read-modify-write of the column accumulators, mean division at block
// end and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_pixel_bin_average_top_defines.svh"

module mpba_back #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int PIXEL_BITS    = 16,
    parameter int ADDR_W        = 10,
    parameter int CNT_W         = 13,
    parameter int SUM_W         = 28
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              pop_valid,
    output logic                             pop_ready,
    input  wire  [PIXEL_BITS-1:0]            pop_pixel,
    input  wire  [ADDR_W-1:0]                pop_slot,
    input  mpba_pkg::item_flags_t            pop_flags,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [mpba_pkg::OUT_VAL_W-1:0]   binned_value,
    output logic                             has_data,
    output logic                             row_end,
    output logic                             frame_end
);
    import mpba_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_DIV    = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    // Column accumulators.
    logic [SUM_W-1:0] sum_mem [MAX_OUT_WIDTH];
    logic [CNT_W-1:0] cnt_mem [MAX_OUT_WIDTH];
    logic [SUM_W-1:0] rd_sum_reg;
    logic [CNT_W-1:0] rd_cnt_reg;

    logic [PIXEL_BITS-1:0] pix_reg;
    logic [ADDR_W-1:0]     slot_reg;
    item_flags_t           flags_reg;
    logic                  zero_reg;

    logic [OUT_VAL_W-1:0] binned_value_reg;
    logic                 has_data_reg;
    logic                 row_end_reg;
    logic                 frame_end_reg;
    logic                 out_valid_reg;

    logic [SUM_W-1:0] add_val;
    logic [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0] new_cnt;
    logic             mem_re;
    logic             mem_we;
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;
    logic             res_ready;
    logic             out_load;

    // Accumulate, or restart the column on the first pixel of a block.
    assign add_val = flags_reg.pix_valid ? SUM_W'(pix_reg) : '0;
    assign new_sum = flags_reg.first ? add_val : (rd_sum_reg + add_val);
    assign new_cnt = flags_reg.first ? CNT_W'(flags_reg.pix_valid) :
                                       (rd_cnt_reg + CNT_W'(flags_reg.pix_valid));

    assign pop_ready = state_reg == ST_IDLE;
    assign mem_re    = pop_valid && pop_ready;
    assign mem_we    = state_reg == ST_UPDATE;
    assign div_start = (state_reg == ST_UPDATE) && flags_reg.last && (new_cnt != '0);
    assign res_ready = zero_reg || div_done;
    assign out_load  = (state_reg == ST_DIV) && res_ready && (!out_valid_reg || out_ready);

    mpba_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (new_sum),
        .den   (new_cnt),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Sequencer: fetch, update, then divide when the block is complete.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (mem_re)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = flags_reg.last ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            pix_reg   <= pop_pixel;
            slot_reg  <= pop_slot;
            flags_reg <= pop_flags;
        end
        if (state_reg == ST_UPDATE)
        begin
            zero_reg <= new_cnt == '0;
        end
        if (out_load)
        begin
            binned_value_reg <= zero_reg ? '0 : OUT_VAL_W'(div_quo[PIXEL_BITS-1:0]);
            has_data_reg     <= !zero_reg;
            row_end_reg      <= flags_reg.row_end;
            frame_end_reg    <= flags_reg.frame_end;
        end
    end

    // Accumulator memory, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[slot_reg] <= new_sum;
            cnt_mem[slot_reg] <= new_cnt;
        end
        if (mem_re)
        begin
            rd_sum_reg <= sum_mem[pop_slot];
            rd_cnt_reg <= cnt_mem[pop_slot];
        end
    end

    assign out_valid    = out_valid_reg;
    assign binned_value = binned_value_reg;
    assign has_data     = has_data_reg;
    assign row_end      = row_end_reg;
    assign frame_end    = frame_end_reg;

    // Every accumulator write comes right after the read of the same item.
    `MPBA_ASSERT_IMPL(a_write_after_read, mem_we, $past(mem_re), "write without read")
    // The mean of a block never exceeds the pixel range.
    `MPBA_ASSERT_IMPL(a_quo_fits, (state_reg == ST_DIV) && div_done && !zero_reg, (div_quo >> PIXEL_BITS) == '0, "mean out of range")

endmodule

`default_nettype wire
